/* rtl/plt_pkg.sv */
// Package for the positional list table: sizes, opcode and status codes,
// controller states and the control bundles passed between the modules.
// Depends on nothing; the core, cell, scanner and checker files import it.
package plt_pkg;

	// Sizes
	localparam int CAPACITY   = 128;
	localparam int DATA_WIDTH = 32;
	localparam int POS_WIDTH  = 8;
	localparam int IDX_W      = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int CMP_W      = (CNT_W > POS_WIDTH) ? CNT_W : POS_WIDTH;

	// Scan geometry: hits are examined one chunk of LANE cells per cycle
	localparam int LANE       = 8;
	localparam int LANE_W     = $clog2(LANE);
	localparam int NUM_CHUNKS = (CAPACITY + LANE - 1) / LANE;
	localparam int PAD        = NUM_CHUNKS * LANE;
	localparam int CHK_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_SET    = 3'd2,
		OP_GET    = 3'd3,
		OP_LOCATE = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_POS = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_DELETE,
		CMD_SET
	} cell_cmd_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		cell_cmd_t          cmd;
		logic               find_key;
		logic [CMP_W-1:0]   pos;
		logic [CMP_W-1:0]   count;
		word_t              word;
	} cell_ctrl_t;

	// Returned by the hit scanner
	typedef struct packed {
		logic               done;
		logic               found;
		logic [IDX_W-1:0]   pos;
		word_t              data;
	} scan_res_t;

endpackage

/* rtl/plt_if.sv */
// Handshake interfaces for the request and response channels.
// Depends on nothing; widths follow the fixed item fields.
interface plt_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic [7:0]         position;
	logic signed [31:0] value;

	modport source (output valid, opcode, position, value, input ready);
	modport sink (input valid, opcode, position, value, output ready);
	modport monitor (input valid, ready, opcode, position, value);
endinterface

interface plt_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] read_data;
	logic               found;
	logic [6:0]         found_position;
	logic [7:0]         list_length;
	logic               is_empty;

	modport source (output valid, status, read_data, found, found_position, list_length,
		is_empty, input ready);
	modport sink (input valid, status, read_data, found, found_position, list_length,
		is_empty, output ready);
	modport monitor (input valid, ready, status, read_data, found, found_position,
		list_length, is_empty);
endinterface

/* rtl/positional_list_table_core.sv */
// Positional list table: an ordered list of signed words kept in a row of
// shifting cells.
//
// Channels: req carries opcode, position and value (valid/ready); rsp returns
// one item per request with status, read_data, found, found_position,
// list_length and is_empty (valid/ready).
// Operation: one request is in work at a time. req.ready is high only while
// the controller is idle. Insert and set shift or load the cells in parallel.
// Get, delete and locate flag hits in the cells and the scanner walks them
// LANE cells per cycle; delete then shifts the row down in the final scan
// cycle. The chunk scan sets the throughput for get, delete and locate.
// Reset: the entry count clears to zero and the list is empty; cell contents
// are not cleared, as only positions below the count are ever read.
// Stall: a response waits in the output register while rsp.ready is low; the
// next request is accepted meanwhile and its response waits behind it.
module positional_list_table_core
	import plt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	plt_req_if.sink   req,
	plt_rsp_if.source rsp
);

	state_t           state_q, state_d;
	opcode_t          op_q;
	logic [POS_WIDTH-1:0] pos_q;
	word_t            word_q;
	logic [CNT_W-1:0] count_q, count_d;

	status_t          res_status_q, res_status_d;
	logic [31:0]      res_data_q, res_data_d;
	logic             res_found_q, res_found_d;
	logic [6:0]       res_fpos_q, res_fpos_d;

	logic             o_valid_q;
	status_t          o_status_q;
	logic [31:0]      o_data_q;
	logic             o_found_q;
	logic [6:0]       o_fpos_q;
	logic [7:0]       o_len_q;
	logic             o_empty_q;

	logic             accept;
	logic             load_out;
	logic             scan_start;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             pos_in_list;
	logic             pos_ins_ok;
	logic             full;
	cell_ctrl_t       ctrl;
	word_t            cell_word [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	scan_res_t        scan;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	assign pos_ext     = CMP_W'(pos_q);
	assign cnt_ext     = CMP_W'(count_q);
	assign pos_in_list = pos_ext < cnt_ext;
	assign pos_ins_ok  = pos_ext <= cnt_ext;
	assign full        = (count_q == CNT_W'(CAPACITY));

	// Controller: next state, cell command and result
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		res_status_d = res_status_q;
		res_data_d   = res_data_q;
		res_found_d  = res_found_q;
		res_fpos_d   = res_fpos_q;
		scan_start   = 1'b0;
		load_out     = 1'b0;
		ctrl.cmd     = CMD_HOLD;
		ctrl.find_key = (op_q == OP_LOCATE);
		ctrl.pos     = pos_ext;
		ctrl.count   = cnt_ext;
		ctrl.word    = word_q;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_status_d = STAT_OK;
				res_data_d   = '0;
				res_found_d  = 1'b0;
				res_fpos_d   = '0;
				state_d      = S_RESP;
				case (op_q)
					OP_INSERT: begin
						if (!pos_ins_ok) begin
							res_status_d = STAT_BAD_POS;
						end else if (full) begin
							res_status_d = STAT_FULL;
						end else begin
							ctrl.cmd = CMD_INSERT;
							count_d  = count_q + 1'b1;
						end
					end
					OP_SET: begin
						if (!pos_in_list) begin
							res_status_d = STAT_BAD_POS;
						end else begin
							ctrl.cmd = CMD_SET;
						end
					end
					OP_DELETE, OP_GET: begin
						if (!pos_in_list) begin
							res_status_d = STAT_BAD_POS;
						end else begin
							scan_start = 1'b1;
							state_d    = S_SCAN;
						end
					end
					OP_LOCATE: begin
						scan_start = 1'b1;
						state_d    = S_SCAN;
					end
					default: begin
					end
				endcase
			end
			S_SCAN: begin
				if (scan.done) begin
					state_d = S_RESP;
					if (op_q == OP_LOCATE) begin
						res_found_d = scan.found;
						res_fpos_d  = scan.found ? 7'(scan.pos) : '0;
					end else begin
						res_data_d = 32'($signed(scan.data));
					end
					if (op_q == OP_DELETE) begin
						ctrl.cmd = CMD_DELETE;
						count_d  = count_q - 1'b1;
					end
				end
			end
			S_RESP: begin
				if (!o_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state, count and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	// Latch the request, the result and the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode_t'(req.opcode);
			pos_q  <= req.position;
			word_q <= DATA_WIDTH'($unsigned(req.value));
		end
		res_status_q <= res_status_d;
		res_data_q   <= res_data_d;
		res_found_q  <= res_found_d;
		res_fpos_q   <= res_fpos_d;
		if (load_out) begin
			o_status_q <= res_status_q;
			o_data_q   <= res_data_q;
			o_found_q  <= res_found_q;
			o_fpos_q   <= res_fpos_q;
			o_len_q    <= 8'(count_q);
			o_empty_q  <= (count_q == '0);
		end
	end

	// Row of cells
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		word_t prev_w;
		word_t next_w;
		if (j == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_mid_prev
			assign prev_w = cell_word[j-1];
		end
		if (j == CAPACITY - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_mid_next
			assign next_w = cell_word[j+1];
		end
		plt_cell u_cell (
			.clk       (clk),
			.idx       (CMP_W'(j)),
			.ctrl      (ctrl),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (cell_word[j]),
			.hit       (cell_hit[j])
		);
	end

	plt_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.hits   (cell_hit),
		.words  (cell_word),
		.res    (scan)
	);

	assign rsp.valid          = o_valid_q;
	assign rsp.status         = o_status_q;
	assign rsp.read_data      = o_data_q;
	assign rsp.found          = o_found_q;
	assign rsp.found_position = o_fpos_q;
	assign rsp.list_length    = o_len_q;
	assign rsp.is_empty       = o_empty_q;

endmodule

/* rtl/plt_cell.sv */
// One storage cell of the list: holds a word, shifts to and from its
// neighbours, and flags a hit for the scanner. Depends on plt_pkg.
module plt_cell
	import plt_pkg::*;
(
	input  logic             clk,
	input  logic [CMP_W-1:0] idx,
	input  cell_ctrl_t       ctrl,
	input  word_t            prev_word,
	input  word_t            next_word,
	output word_t            word,
	output logic             hit
);

	word_t word_q;

	// Load, shift up, shift down or hold
	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_INSERT: begin
				if (idx == ctrl.pos) begin
					word_q <= ctrl.word;
				end else if (idx > ctrl.pos) begin
					word_q <= prev_word;
				end
			end
			CMD_DELETE: begin
				if (idx >= ctrl.pos) begin
					word_q <= next_word;
				end
			end
			CMD_SET: begin
				if (idx == ctrl.pos) begin
					word_q <= ctrl.word;
				end
			end
			default: begin
			end
		endcase
	end

	// Key match inside the list, or position select
	always_comb begin
		if (ctrl.find_key) begin
			hit = (word_q == ctrl.word) && (idx < ctrl.count);
		end else begin
			hit = (idx == ctrl.pos);
		end
	end

	assign word = word_q;

endmodule

/* rtl/plt_scan.sv */
// Hit scanner: folds the cell hits into per-chunk summaries, then walks
// the chunks one per cycle to find the first hit. Depends on plt_pkg.
module plt_scan
	import plt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CAPACITY-1:0] hits,
	input  word_t               words [CAPACITY],
	output scan_res_t           res
);

	logic [PAD-1:0]    hit_pad;
	word_t             masked [PAD];
	logic              cap_any  [NUM_CHUNKS];
	logic [LANE_W-1:0] cap_off  [NUM_CHUNKS];
	word_t             cap_data [NUM_CHUNKS];
	logic              any_q    [NUM_CHUNKS];
	logic [LANE_W-1:0] off_q    [NUM_CHUNKS];
	word_t             data_q   [NUM_CHUNKS];
	logic [CHK_W-1:0]  cnt_q;
	logic              busy_q;
	logic              last_chunk;

	// Pad the hit row to whole chunks; mask out words that do not hit
	for (genvar j = 0; j < PAD; j++) begin : g_pad
		if (j < CAPACITY) begin : g_real
			assign hit_pad[j] = hits[j];
			assign masked[j]  = hits[j] ? words[j] : '0;
		end else begin : g_fill
			assign hit_pad[j] = 1'b0;
			assign masked[j]  = '0;
		end
	end

	// Summarise each chunk: any hit, first hit offset, OR of hit words
	always_comb begin
		for (int c = 0; c < NUM_CHUNKS; c++) begin
			cap_any[c]  = 1'b0;
			cap_off[c]  = '0;
			cap_data[c] = '0;
			for (int k = LANE - 1; k >= 0; k--) begin
				if (hit_pad[c*LANE + k]) begin
					cap_any[c] = 1'b1;
					cap_off[c] = LANE_W'(k);
				end
				cap_data[c] = cap_data[c] | masked[c*LANE + k];
			end
		end
	end

	assign last_chunk = (cnt_q == CHK_W'(NUM_CHUNKS - 1));

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (any_q[0] || last_chunk) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Capture the summaries, then advance them towards the head
	always_ff @(posedge clk) begin
		if (start) begin
			for (int c = 0; c < NUM_CHUNKS; c++) begin
				any_q[c]  <= cap_any[c];
				off_q[c]  <= cap_off[c];
				data_q[c] <= cap_data[c];
			end
		end else if (busy_q) begin
			for (int c = 0; c < NUM_CHUNKS - 1; c++) begin
				any_q[c]  <= any_q[c+1];
				off_q[c]  <= off_q[c+1];
				data_q[c] <= data_q[c+1];
			end
		end
	end

	assign res.done  = busy_q && (any_q[0] || last_chunk);
	assign res.found = any_q[0];
	assign res.pos   = IDX_W'({cnt_q, off_q[0]});
	assign res.data  = data_q[0];

endmodule

/* rtl/plt_checker.sv */
// Port-level checks for the positional list table, bound to the top level.
// Depends on plt_pkg and positional_list_table_core.
module plt_checker
	import plt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [1:0]  rsp_status,
	input  logic [31:0] rsp_read_data,
	input  logic        rsp_found,
	input  logic [6:0]  rsp_found_position,
	input  logic [7:0]  rsp_list_length,
	input  logic        rsp_is_empty
);

	// One request in work at a time
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request accepted while another is in work");

	// Length within capacity and empty flag consistent
	a_len_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_list_length <= 8'(CAPACITY)) &&
			(rsp_is_empty == (rsp_list_length == 8'd0))))
		else $error("list length or empty flag inconsistent");

	// A miss reports position zero
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_found) |-> (rsp_found_position == 7'd0))
		else $error("miss with non-zero found position");

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_read_data) &&
			$stable(rsp_status) && $stable(rsp_list_length)))
		else $error("stalled response changed");

endmodule

bind positional_list_table_core plt_checker u_plt_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_read_data      (rsp.read_data),
	.rsp_found          (rsp.found),
	.rsp_found_position (rsp.found_position),
	.rsp_list_length    (rsp.list_length),
	.rsp_is_empty       (rsp.is_empty)
);
